/* hdl/cqorl_pkg.sv */
// shared types and constants for the command queue with override and rate limit
package cqorl_pkg;

  localparam int unsigned ReqW = 2;
  localparam int unsigned EvtW = 2;
  localparam int unsigned TallyW = 32;
  localparam int unsigned LimitW = 4;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned HoldW = 24;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned PayloadW = 32;

  typedef enum logic [ReqW-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_TICK = 2'd1,
    REQ_ACK  = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [EvtW-1:0] {
    EVT_NONE    = 2'd0,
    EVT_APPLIED = 2'd1,
    EVT_STOPPED = 2'd2,
    EVT_ERROR   = 2'd3
  } evt_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_LIMIT    = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_HOLD     = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PURGE,
    ST_FILTER,
    ST_EVICT,
    ST_APPEND,
    ST_ISSUE,
    ST_DONE
  } state_e;

  // request payload
  typedef struct packed {
    logic [ReqW-1:0]     req_type;
    logic                origin_manual;
    logic                cmd_stop;
    logic [PayloadW-1:0] cmd_payload;
    logic                exec_ok;
  } req_t;

  // response payload
  typedef struct packed {
    logic                accepted;
    logic                issue_valid;
    logic                issue_stop;
    logic [PayloadW-1:0] issue_payload;
    logic [EvtW-1:0]     event_code;
    logic [LimitW-1:0]   queue_count;
    logic                override_active;
    logic [TallyW-1:0]   queued_total;
    logic [TallyW-1:0]   executed_total;
    logic [TallyW-1:0]   dropped_total;
    logic [TallyW-1:0]   error_total;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, do tick/ack work
    logic compact;   // one compaction step
    logic evict;     // pop head, count drop
    logic append;    // append or stop-replace
    logic issue;     // issue check
    logic present;   // load output register
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_enq;
    logic enq_ok;
    logic manual;
    logic stop;
    logic scan_done;
    logic at_limit;
  } stat_t;

  function automatic logic [TallyW-1:0] sat_add(input logic [TallyW-1:0] v,
                                                input logic [TallyW-1:0] n);
    logic [TallyW:0] s;
    s = {1'b0, v} + {1'b0, n};
    return s[TallyW] ? {TallyW{1'b1}} : s[TallyW-1:0];
  endfunction

endpackage

/* hdl/cqorl_if.sv */
// valid/ready channel carrying a payload struct
interface cqorl_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/cqorl_ctrl.sv */
// sequencer stepping one request through queue update and issue
module cqorl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  cqorl_pkg::stat_t stat_i,
  output cqorl_pkg::ctrl_t ctrl_o
);
  import cqorl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PURGE;
      ST_PURGE: begin
        if (!stat_i.is_enq || !stat_i.enq_ok) state_d = ST_ISSUE;
        else if (!stat_i.manual) state_d = ST_FILTER;
        else if (stat_i.scan_done) state_d = stat_i.stop ? ST_APPEND : ST_FILTER;
      end
      ST_FILTER: begin
        if (stat_i.stop) state_d = ST_APPEND;
        else if (stat_i.scan_done) state_d = ST_EVICT;
      end
      ST_EVICT:  if (!stat_i.at_limit) state_d = ST_APPEND;
      ST_APPEND: state_d = ST_ISSUE;
      ST_ISSUE:  state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE:   ctrl_o.load = in_valid_i;
      ST_PURGE:  ctrl_o.compact = stat_i.is_enq && stat_i.enq_ok && stat_i.manual;
      ST_FILTER: ctrl_o.compact = !stat_i.stop;
      ST_EVICT:  ctrl_o.evict = stat_i.at_limit;
      ST_APPEND: ctrl_o.append = 1'b1;
      ST_ISSUE:  ctrl_o.issue = 1'b1;
      ST_DONE:   ctrl_o.present = !out_valid_q || out_ready_i;
      default:   ctrl_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (ctrl_o.present) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
endmodule

/* hdl/cqorl_dp.sv */
// queue storage, timers, tallies and result register
module cqorl_dp #(
  parameter int unsigned QueueDepth  = 8,
  parameter int unsigned PayloadBits = 32,
  parameter int unsigned IdxW        = (QueueDepth > 1) ? $clog2(QueueDepth) : 1,
  parameter int unsigned CntW        = $clog2(QueueDepth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cqorl_pkg::ReqW-1:0]  req_type_i,
  input  logic                        origin_manual_i,
  input  logic                        cmd_stop_i,
  input  logic [PayloadBits-1:0]      cmd_payload_i,
  input  logic                        exec_ok_i,
  input  logic [cqorl_pkg::LimitW-1:0]    queue_limit_i,
  input  logic [cqorl_pkg::IntervalW-1:0] min_interval_i,
  input  logic [cqorl_pkg::HoldW-1:0]     hold_ticks_i,
  input  cqorl_pkg::ctrl_t            ctrl_i,
  output cqorl_pkg::stat_t            stat_o,
  output logic                        accepted_o,
  output logic                        issue_valid_o,
  output logic                        issue_stop_o,
  output logic [PayloadBits-1:0]      issue_payload_o,
  output logic [cqorl_pkg::EvtW-1:0]  event_code_o,
  output logic [cqorl_pkg::LimitW-1:0] queue_count_o,
  output logic                        override_active_o,
  output logic [cqorl_pkg::TallyW-1:0] queued_total_o,
  output logic [cqorl_pkg::TallyW-1:0] executed_total_o,
  output logic [cqorl_pkg::TallyW-1:0] dropped_total_o,
  output logic [cqorl_pkg::TallyW-1:0] error_total_o
);
  import cqorl_pkg::*;

  localparam int unsigned EntW = PayloadBits + 2;

  // entries held in registers: the queue shifts and compacts in place
  logic [EntW-1:0] ent_q [QueueDepth];
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] rd_q, wr_q;   // compaction read and write pointers
  logic [IntervalW-1:0] rate_q;
  logic [HoldW-1:0] hold_q;
  logic busy_q, bstop_q;
  logic [TallyW-1:0] tq_q, te_q, td_q, tr_q;

  logic [ReqW-1:0] req_q;
  logic man_q, stop_q, acc_q;
  logic [PayloadBits-1:0] pay_q;
  logic [EvtW-1:0] evt_q;
  logic iv_q, is_q;
  logic [PayloadBits-1:0] ip_q;
  logic purge_q;

  logic [CntW-1:0] limit;
  always_comb begin
    if (queue_limit_i == '0) limit = CntW'(1);
    else if ({28'd0, queue_limit_i} > 32'(QueueDepth)) limit = CntW'(QueueDepth);
    else limit = CntW'(queue_limit_i);
  end

  logic [IdxW-1:0] rd_idx, wr_idx;
  assign rd_idx = rd_q[IdxW-1:0];
  assign wr_idx = wr_q[IdxW-1:0];
  logic [EntW-1:0] rd_ent;
  assign rd_ent = ent_q[rd_idx];
  logic kill;
  // entry layout {payload, stop, manual}
  always_comb begin
    if (purge_q) kill = !rd_ent[0];
    else kill = (rd_ent[0] == man_q) && !rd_ent[1];
  end

  logic enq_ok;
  assign enq_ok = origin_manual_i || (hold_q == '0);

  assign stat_o.is_enq    = (req_q == REQ_ENQ);
  assign stat_o.enq_ok    = acc_q;
  assign stat_o.manual    = man_q;
  assign stat_o.stop      = stop_q;
  assign stat_o.scan_done = (rd_q >= cnt_q);
  assign stat_o.at_limit  = (cnt_q >= limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= '0; wr_q <= '0;
      rate_q <= '0; hold_q <= '0; busy_q <= 1'b0; bstop_q <= 1'b0;
      tq_q <= '0; te_q <= '0; td_q <= '0; tr_q <= '0;
      req_q <= REQ_NONE; acc_q <= 1'b0; evt_q <= EVT_NONE;
      purge_q <= 1'b0; iv_q <= 1'b0; is_q <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        req_q <= req_type_i;
        man_q <= origin_manual_i;
        stop_q <= cmd_stop_i;
        pay_q <= cmd_payload_i;
        rd_q <= '0; wr_q <= '0;
        purge_q <= origin_manual_i;
        acc_q <= 1'b0;
        evt_q <= EVT_NONE;
        iv_q <= 1'b0; is_q <= 1'b0;
        case (req_e'(req_type_i))
          REQ_ENQ: begin
            acc_q <= enq_ok;
            if (enq_ok && origin_manual_i) hold_q <= hold_ticks_i;
          end
          REQ_TICK: begin
            if (rate_q != '0) rate_q <= rate_q - IntervalW'(1);
            if (hold_q != '0) hold_q <= hold_q - HoldW'(1);
          end
          REQ_ACK: begin
            if (busy_q) begin
              if (exec_ok_i) begin
                te_q <= sat_add(te_q, 32'd1);
                evt_q <= bstop_q ? EVT_STOPPED : EVT_APPLIED;
              end else begin
                tr_q <= sat_add(tr_q, 32'd1);
                evt_q <= EVT_ERROR;
              end
              busy_q <= 1'b0; bstop_q <= 1'b0;
              rate_q <= min_interval_i;
            end
          end
          default: ;
        endcase
      end
      if (ctrl_i.compact) begin
        if (stat_o.scan_done) begin
          cnt_q <= wr_q;
          if (!purge_q) td_q <= sat_add(td_q, 32'(cnt_q - wr_q));
          purge_q <= 1'b0;
          rd_q <= '0; wr_q <= '0;
        end else begin
          rd_q <= rd_q + CntW'(1);
          if (!kill) begin
            ent_q[wr_idx] <= rd_ent;
            wr_q <= wr_q + CntW'(1);
          end
        end
      end
      if (ctrl_i.evict) begin
        for (int i = 0; i < QueueDepth - 1; i++) ent_q[i] <= ent_q[i+1];
        cnt_q <= cnt_q - CntW'(1);
        td_q <= sat_add(td_q, 32'd1);
      end
      if (ctrl_i.append) begin
        tq_q <= sat_add(tq_q, 32'd1);
        if (stop_q) begin
          ent_q[0] <= {pay_q, 1'b1, man_q};
          cnt_q <= CntW'(1);
          td_q <= sat_add(td_q, 32'(cnt_q));
        end else begin
          ent_q[cnt_q[IdxW-1:0]] <= {pay_q, 1'b0, man_q};
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (ctrl_i.issue) begin
        if (!busy_q && cnt_q != '0 && (ent_q[0][1] || rate_q == '0)) begin
          iv_q <= 1'b1;
          is_q <= ent_q[0][1];
          ip_q <= ent_q[0][EntW-1:2];
          for (int i = 0; i < QueueDepth - 1; i++) ent_q[i] <= ent_q[i+1];
          cnt_q <= cnt_q - CntW'(1);
          busy_q <= 1'b1;
          bstop_q <= ent_q[0][1];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.present) begin
      accepted_o        <= stat_o.is_enq && acc_q;
      issue_valid_o     <= iv_q;
      issue_stop_o      <= iv_q & is_q;
      issue_payload_o   <= iv_q ? ip_q : '0;
      event_code_o      <= evt_q;
      queue_count_o     <= LimitW'(cnt_q);
      override_active_o <= (hold_q != '0);
      queued_total_o    <= tq_q;
      executed_total_o  <= te_q;
      dropped_total_o   <= td_q;
      error_total_o     <= tr_q;
    end
  end
endmodule

/* hdl/command_queue_override_rate_limit.sv */
// top level of the command queue with manual override and rate limit
// Each request (enqueue, tick or executor acknowledge) runs through the sequencer states
// from acceptance to response, plus any wait on the response side: a manual enqueue walks the
// queue once to purge automatic entries, and an accepted enqueue that is not a stop walks it
// once more to drop replaced entries of its own source, one slot per cycle and a closing step,
// then evicts from the head one entry per cycle; ticks and acknowledges skip these walks.
// One request is in flight at a time and the result register holds one response.
module command_queue_override_rate_limit #(
  parameter int unsigned QUEUE_DEPTH  = 8,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  cqorl_if.sink   req_if,
  cqorl_if.source rsp_if,
  input  logic                             cfg_we_i,
  input  logic [cqorl_pkg::CfgAddrW-1:0]   cfg_idx_i,
  input  logic [cqorl_pkg::CfgDataW-1:0]   cfg_data_i
);
  import cqorl_pkg::*;

  logic [LimitW-1:0]    limit_q;
  logic [IntervalW-1:0] interval_q;
  logic [HoldW-1:0]     hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitW'(8);
      interval_q <= IntervalW'(1000);
      hold_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_LIMIT:    limit_q <= cfg_data_i[LimitW-1:0];
        CFG_INTERVAL: interval_q <= cfg_data_i[IntervalW-1:0];
        CFG_HOLD:     hold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ctrl_t ctrl;
  stat_t stat;
  logic [PAYLOAD_BITS-1:0] issue_payload;

  cqorl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid),
    .in_ready_o (req_if.ready),
    .out_valid_o(rsp_if.valid),
    .out_ready_i(rsp_if.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  cqorl_dp #(.QueueDepth(QUEUE_DEPTH), .PayloadBits(PAYLOAD_BITS)) u_dp (
    .clk_i, .rst_ni,
    .req_type_i       (req_if.data.req_type),
    .origin_manual_i  (req_if.data.origin_manual),
    .cmd_stop_i       (req_if.data.cmd_stop),
    .cmd_payload_i    (PAYLOAD_BITS'(req_if.data.cmd_payload)),
    .exec_ok_i        (req_if.data.exec_ok),
    .queue_limit_i    (limit_q),
    .min_interval_i   (interval_q),
    .hold_ticks_i     (hold_q),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .accepted_o       (rsp_if.data.accepted),
    .issue_valid_o    (rsp_if.data.issue_valid),
    .issue_stop_o     (rsp_if.data.issue_stop),
    .issue_payload_o  (issue_payload),
    .event_code_o     (rsp_if.data.event_code),
    .queue_count_o    (rsp_if.data.queue_count),
    .override_active_o(rsp_if.data.override_active),
    .queued_total_o   (rsp_if.data.queued_total),
    .executed_total_o (rsp_if.data.executed_total),
    .dropped_total_o  (rsp_if.data.dropped_total),
    .error_total_o    (rsp_if.data.error_total)
  );

  assign rsp_if.data.issue_payload = PayloadW'(issue_payload);

  // a stalled response keeps its queued total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid && !rsp_if.ready |=> $stable(rsp_if.data.queued_total))
    else $error("response changed while stalled");
  // no new request while a step is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_if.valid && req_if.ready |=> !req_if.ready)
    else $error("request taken twice");
  // stop flag only with issue valid flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid && !rsp_if.data.issue_valid |-> !rsp_if.data.issue_stop)
    else $error("stop flag without issue");
endmodule

/* tb/tb_command_queue_override_rate_limit.sv */
// testbench for the command queue with manual override and rate limit
module tb_command_queue_override_rate_limit;
  import cqorl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pay;
    logic        stop;
    logic        man;
  } slot_t;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } row_t;

  localparam int unsigned Depth = 8;
  localparam int unsigned IdleLimit = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cqorl_if #(.T(req_t)) req_ch ();
  cqorl_if #(.T(rsp_t)) rsp_ch ();

  command_queue_override_rate_limit dut (
    .clk_i, .rst_ni, .req_if(req_ch), .rsp_if(rsp_ch),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [LimitW-1:0]    lim_reg = 4'd8;
  logic [IntervalW-1:0] ival_reg = 16'd1000;
  logic [HoldW-1:0]     hold_reg = '0;
  slot_t                slots [Depth];
  int unsigned          n_slots;
  logic [IntervalW-1:0] rate_cnt;
  logic [HoldW-1:0]     hold_cnt;
  bit                   exec_busy, exec_stop;
  logic [TallyW-1:0]    n_queued, n_executed, n_dropped, n_error;

  rsp_t      outcome_q [$];
  bit        typed_pending = 0;
  rsp_t      typed_rsp;
  int        n_req_taken = 0, n_rsp_taken = 0;
  int        errors = 0;
  int        idle_cycles = 0;
  bit        long_stall = 0;

  function automatic logic [TallyW-1:0] bump(logic [TallyW-1:0] v, int unsigned n);
    logic [TallyW:0] s;
    s = {1'b0, v} + n;
    return s[TallyW] ? {TallyW{1'b1}} : s[TallyW-1:0];
  endfunction

  // removes auto entries (purge) or same-source non-stop entries; returns removed count
  function automatic int unsigned squeeze(bit purge, bit src);
    int unsigned w;
    int unsigned gone;
    bit kill;
    w = 0;
    for (int i = 0; i < n_slots; i++) begin
      kill = purge ? !slots[i].man : (slots[i].man == src && !slots[i].stop);
      if (!kill) begin
        slots[w] = slots[i];
        w++;
      end
    end
    gone = n_slots - w;
    n_slots = w;
    return gone;
  endfunction

  function automatic void shift_head();
    for (int i = 0; i < Depth - 1; i++) slots[i] = slots[i+1];
    n_slots--;
  endfunction

  function automatic bit enqueue(req_t r);
    int unsigned lim;
    slot_t e;
    if (!r.origin_manual && hold_cnt != 0) return 0;
    if (r.origin_manual) begin
      hold_cnt = hold_reg;
      void'(squeeze(1, 0));
    end
    e = '{pay: r.cmd_payload, stop: r.cmd_stop, man: r.origin_manual};
    if (r.cmd_stop) begin
      n_dropped = bump(n_dropped, n_slots);
      slots[0] = e;
      n_slots = 1;
    end else begin
      n_dropped = bump(n_dropped, squeeze(0, r.origin_manual));
      lim = lim_reg;
      if (lim < 1) lim = 1;
      if (lim > Depth) lim = Depth;
      while (n_slots >= lim) begin
        shift_head();
        n_dropped = bump(n_dropped, 1);
      end
      slots[n_slots] = e;
      n_slots++;
    end
    n_queued = bump(n_queued, 1);
    return 1;
  endfunction

  function automatic rsp_t predict_outcome(req_t r);
    rsp_t o;
    o = '0;
    case (r.req_type)
      REQ_ENQ: o.accepted = enqueue(r);
      REQ_TICK: begin
        if (rate_cnt != 0) rate_cnt--;
        if (hold_cnt != 0) hold_cnt--;
      end
      REQ_ACK: begin
        if (exec_busy) begin
          if (r.exec_ok) begin
            n_executed = bump(n_executed, 1);
            o.event_code = exec_stop ? EVT_STOPPED : EVT_APPLIED;
          end else begin
            n_error = bump(n_error, 1);
            o.event_code = EVT_ERROR;
          end
          exec_busy = 0;
          exec_stop = 0;
          rate_cnt = ival_reg;
        end
      end
      default: ;
    endcase
    if (!exec_busy && n_slots > 0 && (slots[0].stop || rate_cnt == 0)) begin
      o.issue_valid = 1'b1;
      o.issue_stop = slots[0].stop;
      o.issue_payload = slots[0].pay;
      exec_stop = slots[0].stop;
      exec_busy = 1;
      shift_head();
    end
    o.queue_count = n_slots[3:0];
    o.override_active = hold_cnt != 0;
    o.queued_total = n_queued;
    o.executed_total = n_executed;
    o.dropped_total = n_dropped;
    o.error_total = n_error;
    return o;
  endfunction

  function automatic void clear_model();
    n_slots = 0;
    rate_cnt = '0;
    hold_cnt = '0;
    exec_busy = 0;
    exec_stop = 0;
    n_queued = '0;
    n_executed = '0;
    n_dropped = '0;
    n_error = '0;
  endfunction

  // request acceptance
  always @(posedge clk_i) begin
    rsp_t o;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      o = predict_outcome(req_ch.data);
      if (typed_pending) begin
        o = typed_rsp;
        typed_pending = 0;
      end
      outcome_q = {outcome_q, o};
      n_req_taken++;
    end
  end

  always @(posedge clk_i) begin
    rsp_t w, g;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      g = rsp_ch.data;
      n_rsp_taken++;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected response, expected none actual %0h", $time, g);
        errors++;
      end else begin
        w = outcome_q[0];
        outcome_q.delete(0);
        if (g !== w) begin
          $display("%0t: response expected %0h actual %0h", $time, w, g);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // response side back-pressure
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rsp_ch.ready = 1'b0;
      if (long_stall) begin
        repeat (300) @(negedge clk_i);
        long_stall = 0;
      end else begin
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end
      rsp_ch.ready = 1'b1;
      n = n_rsp_taken;
      do @(negedge clk_i); while (n_rsp_taken == n);
      rsp_ch.ready = 1'b0;
      if ($urandom_range(0, 3) == 0) continue;
      // stretch with no back-pressure
      rsp_ch.ready = 1'b1;
      n = n_rsp_taken;
      do @(negedge clk_i); while (n_rsp_taken == n);
    end
  end

  task automatic send(req_t r, int gap);
    int n;
    repeat (gap) @(negedge clk_i);
    req_ch.data = r;
    req_ch.valid = 1'b1;
    n = n_req_taken;
    do @(negedge clk_i); while (n_req_taken == n);
    req_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_LIMIT: lim_reg = v[LimitW-1:0];
      CFG_INTERVAL: ival_reg = v[IntervalW-1:0];
      default: hold_reg = v[HoldW-1:0];
    endcase
  endtask

  function automatic req_t mk_req(logic [1:0] t, bit man, bit stp, logic [31:0] pay, bit ok);
    req_t r;
    r.req_type = t;
    r.origin_manual = man;
    r.cmd_stop = stp;
    r.cmd_payload = pay;
    r.exec_ok = ok;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(bit acc, bit iv, bit is, logic [31:0] ip, logic [1:0] ev,
                                  int cnt, int q, int ex, int dr, int er);
    rsp_t o;
    o = '0;
    o.accepted = acc;
    o.issue_valid = iv;
    o.issue_stop = is;
    o.issue_payload = ip;
    o.event_code = ev;
    o.queue_count = LimitW'(cnt);
    o.queued_total = q;
    o.executed_total = ex;
    o.dropped_total = dr;
    o.error_total = er;
    return o;
  endfunction

  function automatic req_t rand_req();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45)
      return mk_req(REQ_ENQ, $urandom_range(0, 9) < 4, $urandom_range(0, 6) == 0,
                    $urandom, 1'($urandom_range(0, 1)));
    else if (k < 75)
      return mk_req(REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom, 1);
    else if (k < 95)
      return mk_req(REQ_ACK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                    $urandom_range(0, 3) != 0);
    return mk_req(REQ_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                  1'($urandom_range(0, 1)));
  endfunction

  row_t directed [$];
  logic [CfgDataW-1:0] phase_cfg [8][3] = '{
    '{4'd1, 16'd0, 24'd0},
    '{4'd3, 16'd2, 24'd5},
    '{4'd0, 16'd1, 24'd3},
    '{4'd15, 16'd4, 24'd0},
    '{4'd8, 16'd65535, 24'hFFFFFF},
    '{4'd5, 16'd3, 24'd2},
    '{4'd2, 16'd0, 24'd1},
    '{4'd9, 16'd1, 24'd8}
  };

  function automatic void add_row(req_t r, bit typed, rsp_t want);
    directed.insert(directed.size(), '{r, typed, want});
  endfunction

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    clear_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle executor, reset settings
    add_row(mk_req(REQ_ACK, 0, 0, 0, 1), 1, mk_rsp(0,0,0,0,EVT_NONE,0,0,0,0,0));
    add_row(mk_req(REQ_TICK, 1, 1, 0, 0), 1, mk_rsp(0,0,0,0,EVT_NONE,0,0,0,0,0));
    add_row(mk_req(REQ_NONE, 1, 1, '1, 1), 1, mk_rsp(0,0,0,0,EVT_NONE,0,0,0,0,0));
    add_row(mk_req(REQ_ENQ, 0, 0, '1, 0), 1, mk_rsp(1,1,0,'1,EVT_NONE,0,1,0,0,0));
    add_row(mk_req(REQ_ACK, 0, 0, 0, 1), 1, mk_rsp(0,0,0,0,EVT_APPLIED,0,1,1,0,0));
    // rate limit holds the next command back
    add_row(mk_req(REQ_ENQ, 0, 0, 0, 0), 1, mk_rsp(1,0,0,0,EVT_NONE,1,2,1,0,0));
    // same source replaces
    add_row(mk_req(REQ_ENQ, 0, 0, 1, 0), 1, mk_rsp(1,0,0,0,EVT_NONE,1,3,1,1,0));
    // manual purges auto without counting
    add_row(mk_req(REQ_ENQ, 1, 0, 2, 0), 1, mk_rsp(1,0,0,0,EVT_NONE,1,4,1,1,0));
    // stop drops everything and issues at once
    add_row(mk_req(REQ_ENQ, 0, 1, 3, 0), 1, mk_rsp(1,1,1,3,EVT_NONE,0,5,1,2,0));
    add_row(mk_req(REQ_ACK, 0, 0, 0, 0), 1, mk_rsp(0,0,0,0,EVT_ERROR,0,5,1,2,1));
    add_row(mk_req(REQ_ACK, 1, 1, 0, 1), 1, mk_rsp(0,0,0,0,EVT_NONE,0,5,1,2,1));
    add_row(mk_req(REQ_ENQ, 1, 1, 32'h8000_0001, 1), 0, '0);
    add_row(mk_req(REQ_ENQ, 0, 0, 32'h5555_AAAA, 1), 0, '0);
    add_row(mk_req(REQ_ENQ, 1, 0, 32'hAAAA_5555, 1), 0, '0);
    add_row(mk_req(REQ_ENQ, 0, 0, 32'h0F0F_F0F0, 1), 0, '0);
    add_row(mk_req(REQ_ACK, 0, 0, 0, 1), 0, '0);
    for (int i = 0; i < 3; i++)
      add_row(mk_req(REQ_TICK, 0, 0, 0, 0), 0, '0);

    foreach (directed[i]) begin
      @(negedge clk_i);
      typed_pending = directed[i].typed;
      typed_rsp = directed[i].want;
      send(directed[i].r, 0);
      if (directed[i].typed) begin
        // keep the predictor honest against the hand-written rows
        while (outcome_q.size() != 0) @(negedge clk_i);
      end
    end
    drain();

    for (int p = 0; p < 8; p++) begin
      cfg_write(CFG_LIMIT, phase_cfg[p][0]);
      cfg_write(CFG_INTERVAL, phase_cfg[p][1]);
      cfg_write(CFG_HOLD, phase_cfg[p][2]);
      for (int i = 0; i < 117; i++) begin
        if (p == 1 && i == 40) long_stall = 1;
        if (p == 3 && i == 60) while (outcome_q.size() != 0) @(negedge clk_i);
        send(rand_req(), (i % 40 < 15) ? 0 : $urandom_range(0, 10));
      end
      drain();
    end

    if (errors == 0 && outcome_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
